// File: sv/ssd_pkg.sv
// Shared types, codes and constants of the sample stream deserializer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ssd_pkg;

  localparam int unsigned CHANNEL_INDEX_BITS = 16;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  localparam logic [CfgIndexWidth-1:0] REG_FORMAT = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_COUNT  = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SWAP   = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_FLUSH  = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_TAG    = 3'd4;

  localparam logic [2:0] FMT_INT8    = 3'd0;
  localparam logic [2:0] FMT_INT16   = 3'd1;
  localparam logic [2:0] FMT_INT32   = 3'd2;
  localparam logic [2:0] FMT_INT64   = 3'd3;
  localparam logic [2:0] FMT_FLOAT32 = 3'd4;
  localparam logic [2:0] FMT_FLOAT64 = 3'd5;
  localparam logic [2:0] FMT_STRING  = 3'd6;

  localparam logic [31:0] F32_MAG_MASK  = 32'h7fffffff;
  localparam logic [31:0] F32_FRAC_MAX  = 32'h007fffff;
  localparam logic [31:0] F32_SIGN_MASK = 32'h80000000;
  localparam logic [63:0] F64_MAG_MASK  = 64'h7fffffffffffffff;
  localparam logic [63:0] F64_FRAC_MAX  = 64'h000fffffffffffff;
  localparam logic [63:0] F64_SIGN_MASK = 64'h8000000000000000;

  typedef enum logic [2:0] {
    KIND_STAMP    = 3'd0,
    KIND_DEDUCED  = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_LENGTH   = 3'd3,
    KIND_STR_BYTE = 3'd4,
    KIND_BAD_SIZE = 3'd5
  } kind_e;

  typedef struct packed {
    logic [2:0]  format;
    logic [15:0] count;
    logic        swap;
    logic        flush;
    logic [7:0]  tag;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [15:0] index;
    logic        last;
  } result_t;

  // Number of bytes a numeric channel occupies; string and unused codes count as one.
  function automatic logic [3:0] fmt_width(input logic [2:0] fmt);
    logic [3:0] w;
    case (fmt)
      FMT_INT8:    w = 4'd1;
      FMT_INT16:   w = 4'd2;
      FMT_INT32:   w = 4'd4;
      FMT_INT64:   w = 4'd8;
      FMT_FLOAT32: w = 4'd4;
      FMT_FLOAT64: w = 4'd8;
      default:     w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: sv/ssd_cfg_regs.sv
// Configuration register file of the sample stream deserializer.
// Depends on ssd_pkg for register indexes and the configuration struct.
`default_nettype none

module ssd_cfg_regs (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [ssd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  wire [ssd_pkg::CfgDataWidth-1:0]    cfg_data_i,
  output ssd_pkg::cfg_t                      cfg_o
);
  import ssd_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format <= FMT_FLOAT32;
      cfg_q.count  <= 16'd1;
      cfg_q.swap   <= 1'b0;
      cfg_q.flush  <= 1'b0;
      cfg_q.tag    <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FORMAT: cfg_q.format <= cfg_data_i[2:0];
        REG_COUNT:  cfg_q.count  <= cfg_data_i[15:0];
        REG_SWAP:   cfg_q.swap   <= cfg_data_i[0];
        REG_FLUSH:  cfg_q.flush  <= cfg_data_i[0];
        REG_TAG:    cfg_q.tag    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/ssd_parser.sv
// Input byte register and record parse state of the sample stream deserializer.
// Depends on ssd_pkg; produces at most one result per byte for the output register.
`default_nettype none

module ssd_parser #(
  parameter int unsigned ChannelIndexBits = ssd_pkg::CHANNEL_INDEX_BITS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  ssd_pkg::cfg_t     cfg_i,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire [7:0]         in_byte_i,
  output logic              res_valid_o,
  input  wire               res_ready_i,
  output ssd_pkg::result_t  res_o
);
  import ssd_pkg::*;

  localparam logic [15:0] IdxMask = (ChannelIndexBits >= 16) ? 16'hffff :
      16'((32'd1 << ChannelIndexBits) - 32'd1);

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_STAMP   = 3'd1,
    PH_NUMERIC = 3'd2,
    PH_LENSIZE = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_CONTENT = 3'd5
  } phase_e;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  phase_e      phase_q, phase_d;
  logic [3:0]  byte_count_q, byte_count_d;
  logic [63:0] assembly_q, assembly_d;
  logic [15:0] chan_q, chan_d;
  logic [3:0]  len_size_q, len_size_d;
  logic [63:0] remaining_q, remaining_d;

  logic        step;
  logic        has_res;
  result_t     res;
  logic [3:0]  bc_take;
  logic [63:0] asm_take;
  logic [16:0] next_chan;
  logic        end_last;
  phase_e      begin_phase;
  logic [15:0] idx;
  logic [63:0] rem_dec;
  logic [63:0] v;

  assign step       = in_valid_q && res_ready_i;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  assign bc_take   = byte_count_q + 4'd1;
  assign asm_take  = cfg_i.swap ? {assembly_q[55:0], in_byte_q} :
      (assembly_q | (64'(in_byte_q) << {byte_count_q[2:0], 3'b000}));
  assign next_chan = {1'b0, chan_q} + 17'd1;
  assign end_last  = next_chan >= {1'b0, cfg_i.count};
  assign begin_phase = (cfg_i.format == FMT_STRING) ? PH_LENSIZE : PH_NUMERIC;
  assign idx       = chan_q & IdxMask;
  assign rem_dec   = remaining_q - 64'd1;

  always_comb begin
    v = asm_take;
    if (cfg_i.flush) begin
      if (cfg_i.format == FMT_FLOAT32) begin
        v = {32'd0, asm_take[31:0]};
        if (v != 64'd0 && (v[31:0] & F32_MAG_MASK) <= F32_FRAC_MAX) begin
          v = {32'd0, v[31:0] & F32_SIGN_MASK};
        end
      end else if (cfg_i.format == FMT_FLOAT64) begin
        if (v != 64'd0 && (v & F64_MAG_MASK) <= F64_FRAC_MAX) begin
          v = v & F64_SIGN_MASK;
        end
      end
    end
  end

  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    assembly_d   = assembly_q;
    chan_d       = chan_q;
    len_size_d   = len_size_q;
    remaining_d  = remaining_q;
    has_res      = 1'b0;
    res.kind     = KIND_STAMP;
    res.value    = 64'd0;
    res.index    = 16'd0;
    res.last     = 1'b0;
    case (phase_q)
      PH_TAG: begin
        chan_d       = 16'd0;
        byte_count_d = 4'd0;
        assembly_d   = 64'd0;
        if (in_byte_q == cfg_i.tag) begin
          has_res  = 1'b1;
          res.kind = KIND_DEDUCED;
          res.last = (cfg_i.count == 16'd0);
          phase_d  = res.last ? PH_TAG : begin_phase;
        end else begin
          phase_d = PH_STAMP;
        end
      end
      PH_STAMP: begin
        byte_count_d = bc_take;
        assembly_d   = asm_take;
        if (bc_take >= 4'd8) begin
          has_res      = 1'b1;
          res.kind     = KIND_STAMP;
          res.value    = asm_take;
          res.last     = (cfg_i.count == 16'd0);
          byte_count_d = 4'd0;
          assembly_d   = 64'd0;
          phase_d      = res.last ? PH_TAG : begin_phase;
        end
      end
      PH_NUMERIC: begin
        byte_count_d = bc_take;
        assembly_d   = asm_take;
        if (bc_take >= fmt_width(cfg_i.format)) begin
          has_res      = 1'b1;
          res.kind     = KIND_VALUE;
          res.value    = v;
          res.index    = idx;
          res.last     = end_last;
          byte_count_d = 4'd0;
          assembly_d   = 64'd0;
          chan_d       = end_last ? 16'd0 : next_chan[15:0];
          phase_d      = end_last ? PH_TAG : begin_phase;
        end
      end
      PH_LENSIZE: begin
        byte_count_d = 4'd0;
        assembly_d   = 64'd0;
        if (in_byte_q == 8'd1 || in_byte_q == 8'd2 || in_byte_q == 8'd4 ||
            in_byte_q == 8'd8) begin
          len_size_d = in_byte_q[3:0];
          phase_d    = PH_LENGTH;
        end else begin
          has_res   = 1'b1;
          res.kind  = KIND_BAD_SIZE;
          res.value = 64'(in_byte_q);
          res.index = idx;
          res.last  = 1'b1;
          chan_d    = 16'd0;
          phase_d   = PH_TAG;
        end
      end
      PH_LENGTH: begin
        byte_count_d = bc_take;
        assembly_d   = asm_take;
        if (bc_take >= len_size_q) begin
          has_res   = 1'b1;
          res.kind  = KIND_LENGTH;
          res.value = asm_take;
          res.index = idx;
          if (asm_take == 64'd0) begin
            res.last     = end_last;
            byte_count_d = 4'd0;
            assembly_d   = 64'd0;
            chan_d       = end_last ? 16'd0 : next_chan[15:0];
            phase_d      = end_last ? PH_TAG : begin_phase;
          end else begin
            remaining_d = asm_take;
            phase_d     = PH_CONTENT;
          end
        end
      end
      PH_CONTENT: begin
        remaining_d = rem_dec;
        has_res     = 1'b1;
        res.kind    = KIND_STR_BYTE;
        res.value   = 64'(in_byte_q);
        res.index   = idx;
        if (rem_dec == 64'd0) begin
          res.last     = end_last;
          byte_count_d = 4'd0;
          assembly_d   = 64'd0;
          chan_d       = end_last ? 16'd0 : next_chan[15:0];
          phase_d      = end_last ? PH_TAG : begin_phase;
        end
      end
      default: begin
        phase_d      = PH_TAG;
        byte_count_d = 4'd0;
        assembly_d   = 64'd0;
      end
    endcase
  end

  assign res_valid_o = step && has_res;
  assign res_o       = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TAG;
      byte_count_q <= 4'd0;
      assembly_q   <= 64'd0;
      chan_q       <= 16'd0;
      len_size_q   <= 4'd0;
      remaining_q  <= 64'd0;
    end else if (step) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      assembly_q   <= assembly_d;
      chan_q       <= chan_d;
      len_size_q   <= len_size_d;
      remaining_q  <= remaining_d;
    end
  end

  // A field never collects more than eight bytes before it is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) byte_count_q <= 4'd8)
    else $error("byte count ran past eight");

  // A bad length size always closes the record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid_o && res.kind == KIND_BAD_SIZE) |-> res.last)
    else $error("bad length size result is not the last of its record");

  // After the final result of a record the parser waits for the next tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (res_valid_o && res.last) |=> (phase_q == PH_TAG && chan_q == 16'd0))
    else $error("parser did not return to the tag phase after a record");

endmodule

`default_nettype wire

// File: sv/ssd_out_reg.sv
// Result register of the sample stream deserializer, one stream transaction deep.
// Depends on ssd_pkg for the result struct.
`default_nettype none

module ssd_out_reg (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               res_valid_i,
  output logic              res_ready_o,
  input  ssd_pkg::result_t  res_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output ssd_pkg::result_t  out_o
);
  import ssd_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/sample_stream_deserializer.sv
// Sample stream deserializer: parses serialized sample records one byte per transaction.
// Instantiates ssd_cfg_regs, ssd_parser and ssd_out_reg; depends on ssd_pkg.
//
// The block gives at most one result per byte. Each byte sits in an input register,
// passes the combinational parse logic and its result is written to an output register,
// from which it is presented on the result side. The sustained rate is one byte per cycle
// as long as the result side keeps up. While a result waits in the output register, the
// parser stops, also for bytes that give no result, and the input side takes at most
// one further byte into its register. Configuration writes are always taken and should
// be made only while no transaction is in flight.
`default_nettype none

module sample_stream_deserializer #(
  parameter int unsigned CHANNEL_INDEX_BITS = ssd_pkg::CHANNEL_INDEX_BITS
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [ssd_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  wire [ssd_pkg::CfgDataWidth-1:0]   cfg_data_i,
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire [7:0]                         s_axis_tdata,  // [7:0] in_byte
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  output logic [79:0]                       m_axis_tdata,  // [63:0] value, [79:64] channel_index
  output logic [2:0]                        m_axis_tuser,  // [2:0] kind
  output logic                              m_axis_tlast   // last_of_sample
);
  import ssd_pkg::*;

  cfg_t    cfg;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out;

  ssd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ssd_parser #(
    .ChannelIndexBits (CHANNEL_INDEX_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  ssd_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out)
  );

  assign m_axis_tdata = {out.index, out.value};
  assign m_axis_tuser = out.kind;
  assign m_axis_tlast = out.last;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench of sample_stream_deserializer: streams sample records byte by
// byte under many register settings and checks every result against a built-in parser.
// Depends on ssd_pkg and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import ssd_pkg::*;

  localparam logic [2:0] FMT_UNUSED = 3'd7;
  // Bytes per numeric channel, four bits per format code, code zero lowest.
  localparam logic [31:0] FMT_BYTES = {4'd1, 4'd1, 4'd8, 4'd4, 4'd8, 4'd4, 4'd2, 4'd1};

  typedef enum logic [2:0] {
    ST_TAG, ST_STAMP, ST_NUMERIC, ST_LENSIZE, ST_LENGTH, ST_CONTENT
  } parse_phase_e;

  typedef struct {
    parse_phase_e ph;
    logic [3:0]   cnt;
    logic [63:0]  acc;
    logic [15:0]  chan;
    logic [3:0]   lsize;
    logic [63:0]  remain;
  } parse_state_t;

  typedef logic [7:0] byte_list_t [$];

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [79:0]              m_axis_tdata;
  logic [2:0]               m_axis_tuser;
  logic                     m_axis_tlast;

  sample_stream_deserializer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  cfg_t         dut_cfg;
  parse_state_t record_state;
  parse_state_t lookahead_state;
  logic [63:0]  field_plan;
  logic [7:0]   byte_q [$];
  result_t      expected_results [$];
  bit           no_idle = 1'b0;
  int unsigned  mismatches = 0;
  int unsigned  results_checked = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  settings_count = 0;

  always #5 clk_i = ~clk_i;

  function automatic logic [3:0] numeric_bytes(input logic [2:0] fmt);
    return FMT_BYTES[int'(fmt) * 4 +: 4];
  endfunction

  function automatic void open_channel(inout parse_state_t st, input cfg_t c);
    st.cnt = '0;
    st.acc = '0;
    st.ph = (c.format == FMT_STRING) ? ST_LENSIZE : ST_NUMERIC;
  endfunction

  function automatic bit close_channel(inout parse_state_t st, input cfg_t c);
    logic [16:0] next;
    next = {1'b0, st.chan} + 17'd1;
    if (next >= {1'b0, c.count}) begin
      st.chan = '0;
      st.ph = ST_TAG;
      st.cnt = '0;
      st.acc = '0;
      return 1'b1;
    end
    st.chan = next[15:0];
    open_channel(st, c);
    return 1'b0;
  endfunction

  function automatic void shift_in(inout parse_state_t st, input cfg_t c, input logic [7:0] b);
    if (c.swap) begin
      st.acc = {st.acc[55:0], b};
    end else begin
      st.acc = st.acc | (64'(b) << (int'(st.cnt[2:0]) * 8));
    end
    st.cnt = st.cnt + 4'd1;
  endfunction

  // Advances the parse state by one byte; returns 1 when the byte yields a result.
  function automatic bit parse_byte(inout parse_state_t st, input cfg_t c, input logic [7:0] b,
                                    output result_t r);
    logic [63:0] v;
    r = '0;
    case (st.ph)
      ST_TAG: begin
        st.chan = '0;
        st.cnt = '0;
        st.acc = '0;
        if (b == c.tag) begin
          r.kind = KIND_DEDUCED;
          r.last = (c.count == 16'd0);
          if (!r.last) open_channel(st, c);
          return 1'b1;
        end
        st.ph = ST_STAMP;
        return 1'b0;
      end
      ST_STAMP: begin
        shift_in(st, c, b);
        if (st.cnt < 4'd8) return 1'b0;
        r.kind = KIND_STAMP;
        r.value = st.acc;
        r.last = (c.count == 16'd0);
        if (r.last) begin
          st.ph = ST_TAG;
          st.cnt = '0;
          st.acc = '0;
        end else begin
          open_channel(st, c);
        end
        return 1'b1;
      end
      ST_NUMERIC: begin
        shift_in(st, c, b);
        if (st.cnt < numeric_bytes(c.format)) return 1'b0;
        v = st.acc;
        if (c.flush) begin
          if (c.format == FMT_FLOAT32) begin
            v = {32'h0, v[31:0]};
            if (v != 64'd0 && (v[31:0] & F32_MAG_MASK) <= F32_FRAC_MAX) begin
              v = v & {32'h0, F32_SIGN_MASK};
            end
          end else if (c.format == FMT_FLOAT64) begin
            if (v != 64'd0 && (v & F64_MAG_MASK) <= F64_FRAC_MAX) v = v & F64_SIGN_MASK;
          end
        end
        r.kind = KIND_VALUE;
        r.value = v;
        r.index = st.chan;
        r.last = close_channel(st, c);
        return 1'b1;
      end
      ST_LENSIZE: begin
        if (b == 8'd1 || b == 8'd2 || b == 8'd4 || b == 8'd8) begin
          st.lsize = b[3:0];
          st.cnt = '0;
          st.acc = '0;
          st.ph = ST_LENGTH;
          return 1'b0;
        end
        r.kind = KIND_BAD_SIZE;
        r.value = 64'(b);
        r.index = st.chan;
        r.last = 1'b1;
        st.chan = '0;
        st.ph = ST_TAG;
        st.cnt = '0;
        st.acc = '0;
        return 1'b1;
      end
      ST_LENGTH: begin
        shift_in(st, c, b);
        if (st.cnt < st.lsize) return 1'b0;
        r.kind = KIND_LENGTH;
        r.value = st.acc;
        r.index = st.chan;
        if (st.acc == 64'd0) begin
          r.last = close_channel(st, c);
        end else begin
          st.remain = st.acc;
          st.ph = ST_CONTENT;
          r.last = 1'b0;
        end
        return 1'b1;
      end
      ST_CONTENT: begin
        r.kind = KIND_STR_BYTE;
        r.value = 64'(b);
        r.index = st.chan;
        st.remain = st.remain - 64'd1;
        r.last = 1'b0;
        if (st.remain == 64'd0) r.last = close_channel(st, c);
        return 1'b1;
      end
      default: begin
        st.ph = ST_TAG;
        st.cnt = '0;
        st.acc = '0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [63:0] numeric_plan(input logic [2:0] fmt);
    int unsigned pick;
    logic        s;
    pick = $urandom_range(3);
    s = 1'($urandom_range(1));
    if (fmt == FMT_FLOAT32) begin
      case (pick)
        0: return 64'($urandom);
        1: return 64'({s, 8'h00, 23'($urandom)});
        2: return 64'({s, 31'h0});
        default: return 64'({s, ($urandom_range(1) != 0) ? 31'h00800000 : 31'h007fffff});
      endcase
    end
    if (fmt == FMT_FLOAT64) begin
      case (pick)
        0: return {$urandom, $urandom};
        1: return {s, 11'h000, 21'($urandom), 31'($urandom)};
        2: return {s, 63'h0};
        default: begin
          return {s, ($urandom_range(1) != 0) ? 63'h0010000000000000 : 63'h000fffffffffffff};
        end
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] length_plan(input logic [3:0] w);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 64'd0;
    if (pick < 85) return 64'($urandom_range(6, 1));
    if (pick < 97) return 64'($urandom_range(40, 7));
    return (w >= 4'd2) ? 64'($urandom_range(300, 200)) : 64'($urandom_range(255, 200));
  endfunction

  // Chooses the next byte from where the record stands, mostly well formed.
  function automatic logic [7:0] pick_byte();
    int unsigned pick;
    logic [3:0]  w;
    pick = $urandom_range(99);
    if (lookahead_state.ph != ST_LENGTH && pick < 5) return 8'($urandom);
    case (lookahead_state.ph)
      ST_TAG: return (pick < 55) ? dut_cfg.tag : 8'($urandom);
      ST_LENSIZE: begin
        if (pick < 12) return 8'($urandom);
        return 8'(1 << $urandom_range(3));
      end
      ST_NUMERIC, ST_LENGTH: begin
        if (lookahead_state.ph == ST_NUMERIC) begin
          w = numeric_bytes(dut_cfg.format);
          if (lookahead_state.cnt == 4'd0) field_plan = numeric_plan(dut_cfg.format);
        end else begin
          w = lookahead_state.lsize;
          if (lookahead_state.cnt == 4'd0) field_plan = length_plan(w);
        end
        if (lookahead_state.cnt >= w) return 8'($urandom);
        if (dut_cfg.swap) begin
          return field_plan[(int'(w) - 1 - int'(lookahead_state.cnt)) * 8 +: 8];
        end
        return field_plan[int'(lookahead_state.cnt) * 8 +: 8];
      end
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    result_t scratch;
    void'(parse_byte(lookahead_state, dut_cfg, b, scratch));
    byte_q.push_back(b);
  endtask

  task automatic push_bytes(input byte_list_t bytes);
    foreach (bytes[i]) push_byte(bytes[i]);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FORMAT: dut_cfg.format = data[2:0];
      REG_COUNT:  dut_cfg.count = data;
      REG_SWAP:   dut_cfg.swap = data[0];
      REG_FLUSH:  dut_cfg.flush = data[0];
      REG_TAG:    dut_cfg.tag = data[7:0];
      default: ;
    endcase
  endtask

  // Waits until every byte is taken and every result is back, then lets the pipeline settle.
  task automatic drain();
    while (byte_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_settings(input int phase_no);
    logic [2:0]  fmt;
    logic [15:0] cnt;
    int unsigned pick;
    fmt = ($urandom_range(3) == 0) ? FMT_STRING : 3'($urandom_range(7));
    pick = $urandom_range(99);
    if (phase_no == 2) cnt = 16'hffff;
    else if (pick < 8) cnt = 16'd0;
    else if (pick < 85) cnt = 16'($urandom_range(4, 1));
    else cnt = 16'($urandom_range(12, 5));
    write_reg(REG_FORMAT, 16'(fmt));
    write_reg(REG_COUNT, cnt);
    // A byte order change inside a length field would turn a short length into a huge one.
    if (lookahead_state.ph == ST_LENGTH) write_reg(REG_SWAP, 16'(dut_cfg.swap));
    else write_reg(REG_SWAP, 16'($urandom_range(1)));
    write_reg(REG_FLUSH, 16'($urandom_range(1)));
    write_reg(REG_TAG, 16'($urandom_range(255)));
    settings_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        if (parse_byte(record_state, dut_cfg, s_axis_tdata, res)) expected_results.push_back(res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (byte_q.size() != 0 && (no_idle || $urandom_range(99) >= 38)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= byte_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d value %h", m_axis_tuser, m_axis_tdata[63:0]);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[63:0] !== want.value) begin
          $error("value: expected %h, got %h", want.value, m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[79:64] !== want.index) begin
          $error("channel_index: expected %0d, got %0d", want.index, m_axis_tdata[79:64]);
          mismatches++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_of_sample: expected %0d, got %0d", want.last, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned random_items;
    int          phase_no;
    int unsigned n;
    dut_cfg.format = FMT_FLOAT32;
    dut_cfg.count = 16'd1;
    dut_cfg.swap = 1'b0;
    dut_cfg.flush = 1'b0;
    dut_cfg.tag = 8'd1;
    record_state = '{ph: ST_TAG, cnt: '0, acc: '0, chan: '0, lsize: '0, remain: '0};
    lookahead_state = record_state;
    field_plan = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Records without channels: a deduced stamp, then a transmitted all-ones stamp.
    write_reg(REG_COUNT, 16'd0);
    write_reg(REG_TAG, 16'h00ff);
    push_bytes('{8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    drain();
    // Strings: an empty string, then an invalid length size on the second channel.
    write_reg(REG_FORMAT, 16'(FMT_STRING));
    write_reg(REG_COUNT, 16'd2);
    write_reg(REG_TAG, 16'h0000);
    write_reg(REG_SWAP, 16'd1);
    push_bytes('{8'h00, 8'h01, 8'h00, 8'h03});
    drain();
    // The unused format code reads one byte; the record then carries on as float64.
    write_reg(REG_FORMAT, 16'(FMT_UNUSED));
    write_reg(REG_FLUSH, 16'd1);
    write_reg(REG_SWAP, 16'd0);
    push_bytes('{8'h00, 8'hab});
    drain();
    write_reg(REG_FORMAT, 16'(FMT_FLOAT64));
    push_bytes('{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80});
    drain();
    settings_count = 4;

    random_items = 0;
    for (phase_no = 0; random_items < 1850; phase_no++) begin
      random_settings(phase_no);
      no_idle = (phase_no == 4);
      if (no_idle) n = 300;
      else if (dut_cfg.count == 16'hffff) n = 60;
      else n = $urandom_range(120, 20);
      repeat (n) push_byte(pick_byte());
      random_items += n;
      drain();
    end
    no_idle = 1'b0;

    $display("Checked %0d results from %0d stream bytes under %0d register settings.",
             results_checked, bytes_taken, settings_count);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
